FILE: design/adlc_pkg.sv
// ----------------------------------------------------------------------------
// adlc_pkg
// Shared types and constants of the adjacent duplicate line counter.
// ----------------------------------------------------------------------------
package adlc_pkg;

	localparam int MAX_LINE_DEF = 1024;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 10;

	localparam int COUNT_W = 16;
	localparam int LINE_W  = 32;
	localparam int OUT_DATA_W = COUNT_W + LINE_W;

	localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_COUNTS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_FIELDS = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_CHARS  = CFG_IDX_W'(3);

	localparam logic [1:0] MODE_ALL      = 2'd0;
	localparam logic [1:0] MODE_REPEATED = 2'd1;
	localparam logic [1:0] MODE_SINGLE   = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Control flags of one item on its way from the parser to the group stage.
	typedef struct packed {
		logic eoi;      // input has ended with this item
		logic end_rec;  // this byte closes a record
		logic first;    // first byte of a record
		logic keep;     // byte belongs to the compared rest and was stored
	} item_flags_t;

endpackage

FILE: design/adlc_store.sv
// ----------------------------------------------------------------------------
// adlc_store
// Ping-pong line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module adlc_store #(
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no new item is taken, so a stalled compare keeps it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/adlc_parse.sv
// ----------------------------------------------------------------------------
// adlc_parse
// Input stage: record framing, field and character skipping, store access.
// ----------------------------------------------------------------------------
module adlc_parse #(
	parameter int MAX_LINE = adlc_pkg::MAX_LINE_DEF,
	parameter int LEN_W    = $clog2(MAX_LINE + 1),
	parameter int IDX_W    = $clog2(MAX_LINE)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,
	input  logic                   s_tlast,
	input  logic [7:0]             skip_fields,
	input  logic [9:0]             skip_chars,
	input  logic                   s1_fire,
	input  logic                   bank_rd,
	output logic                   mem_we,
	output logic [IDX_W:0]         mem_waddr,
	output logic                   mem_re,
	output logic [IDX_W:0]         mem_raddr,
	output logic                   valid_s1,
	output adlc_pkg::item_flags_t  flags_s1,
	output logic [7:0]             byte_s1,
	output logic [LEN_W-1:0]       cur_s1,
	output logic [LEN_W-1:0]       cur_new_s1
);

	import adlc_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE);

	logic             finished_q;
	logic [LEN_W-1:0] rec_bytes_q;
	logic [LEN_W-1:0] cur_len_q;
	logic [7:0]       fields_left_q;
	logic             inside_q;
	logic [9:0]       chars_left_q;

	logic             accept;
	logic             work;
	logic             eoi_hit;
	logic             first;
	logic             blank;
	logic             to_chars;
	logic             keep;
	logic             keep_w;
	logic             end_rec;
	logic [7:0]       fl;
	logic [7:0]       fl_n;
	logic             inf;
	logic             inf_n;
	logic [9:0]       cl;
	logic [9:0]       cl_n;
	logic [LEN_W-1:0] cur;
	logic [LEN_W-1:0] cur_n;
	logic [LEN_W-1:0] rb_new;

	assign s_tready = !valid_s1 || s1_fire;
	assign accept   = s_tvalid && s_tready;
	assign work     = accept && !finished_q;

	always_comb begin
		eoi_hit  = s_tlast || (s_tdata == CH_NUL);
		first    = (rec_bytes_q == '0);
		fl       = first ? skip_fields : fields_left_q;
		inf      = first ? 1'b0 : inside_q;
		cl       = first ? skip_chars : chars_left_q;
		cur      = first ? '0 : cur_len_q;
		rb_new   = rec_bytes_q + LEN_W'(1);
		blank    = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
		to_chars = 1'b0;
		fl_n     = fl;
		inf_n    = inf;
		cl_n     = cl;
		keep     = 1'b0;
		if (fl == '0) begin
			to_chars = 1'b1;
		end else if (inf && blank) begin
			fl_n  = fl - 8'd1;
			inf_n = 1'b0;
			if (fl_n == '0) begin
				to_chars = 1'b1;
			end
		end else if (!inf && !blank) begin
			inf_n = 1'b1;
		end
		if (to_chars) begin
			if (cl != '0) begin
				cl_n = cl - 10'd1;
			end else begin
				keep = 1'b1;
			end
		end
		keep_w  = keep && (cur < MAX_LEN);
		cur_n   = cur + LEN_W'(keep_w);
		end_rec = (s_tdata == CH_NL) || (rb_new >= MAX_LEN);
	end

	// The group's rest sits in bank bank_rd, the current rest goes to the other.
	assign mem_re    = work;
	assign mem_we    = work && !eoi_hit && keep_w;
	assign mem_raddr = {bank_rd, cur[IDX_W-1:0]};
	assign mem_waddr = {!bank_rd, cur[IDX_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q    <= 1'b0;
			rec_bytes_q   <= '0;
			cur_len_q     <= '0;
			fields_left_q <= '0;
			inside_q      <= 1'b0;
			chars_left_q  <= '0;
		end else if (work) begin
			if (eoi_hit) begin
				finished_q  <= 1'b1;
				rec_bytes_q <= '0;
				cur_len_q   <= '0;
			end else begin
				rec_bytes_q   <= end_rec ? '0 : rb_new;
				cur_len_q     <= cur_n;
				fields_left_q <= fl_n;
				inside_q      <= inf_n;
				chars_left_q  <= cl_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (work) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			flags_s1.eoi     <= eoi_hit;
			flags_s1.end_rec <= !eoi_hit && end_rec;
			flags_s1.first   <= first;
			flags_s1.keep    <= !eoi_hit && keep_w;
			byte_s1          <= s_tdata;
			cur_s1           <= cur;
			cur_new_s1       <= cur_n;
		end
	end

endmodule

FILE: design/adlc_group.sv
// ----------------------------------------------------------------------------
// adlc_group
// Compare stage and group bookkeeping, with the result register.
// ----------------------------------------------------------------------------
module adlc_group #(
	parameter int MAX_LINE = adlc_pkg::MAX_LINE_DEF,
	parameter int LEN_W    = $clog2(MAX_LINE + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s1,
	input  adlc_pkg::item_flags_t             flags_s1,
	input  logic [7:0]                        byte_s1,
	input  logic [LEN_W-1:0]                  cur_s1,
	input  logic [LEN_W-1:0]                  cur_new_s1,
	input  logic [7:0]                        rdata,
	input  logic [1:0]                        select_mode,
	input  logic                              show_counts,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [adlc_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast,
	output logic                              s1_fire,
	output logic                              bank_rd
);

	import adlc_pkg::*;

	logic               bank_q;
	logic [LEN_W-1:0]   prev_len_q;
	logic               mismatch_q;
	logic               have_prev_q;
	logic [COUNT_W-1:0] run_count_q;
	logic [LINE_W-1:0]  run_start_q;
	logic [LINE_W-1:0]  line_num_q;

	logic               adv;
	logic               mis;
	logic               same_rest;
	logic               start_group;
	logic               emit;
	logic               pr;

	assign adv     = !m_tvalid || m_tready;
	assign s1_fire = valid_s1 && adv;

	always_comb begin
		mis = (!flags_s1.first && mismatch_q) ||
			(flags_s1.keep && ((cur_s1 >= prev_len_q) || (rdata != byte_s1)));
		same_rest   = !mis && (cur_new_s1 == prev_len_q);
		start_group = !flags_s1.eoi && flags_s1.end_rec && (!have_prev_q || !same_rest);
		emit        = flags_s1.eoi ? have_prev_q
			: (flags_s1.end_rec && have_prev_q && !same_rest);
		case (select_mode)
			MODE_REPEATED: pr = (run_count_q != COUNT_W'(1));
			MODE_SINGLE:   pr = (run_count_q == COUNT_W'(1));
			default:       pr = 1'b1;
		endcase
		if (show_counts) begin
			pr = 1'b1;
		end
	end

	// A record that opens a new group swaps the banks; the next byte already
	// reads from the swapped bank.
	assign bank_rd = bank_q ^ (s1_fire && start_group);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= 1'b0;
			prev_len_q  <= '0;
			mismatch_q  <= 1'b0;
			have_prev_q <= 1'b0;
			run_count_q <= '0;
			run_start_q <= '0;
			line_num_q  <= '0;
		end else if (s1_fire) begin
			mismatch_q <= mis;
			if (flags_s1.end_rec) begin
				line_num_q <= line_num_q + LINE_W'(1);
				if (start_group) begin
					have_prev_q <= 1'b1;
					bank_q      <= !bank_q;
					prev_len_q  <= cur_new_s1;
					run_count_q <= COUNT_W'(1);
					run_start_q <= line_num_q;
				end else if (run_count_q != COUNT_MAX) begin
					run_count_q <= run_count_q + COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s1_fire) begin
			m_tvalid <= emit;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			m_tdata <= {run_start_q, run_count_q};
			m_tuser <= pr;
			m_tlast <= flags_s1.eoi;
		end
	end

endmodule

FILE: design/adjacent_duplicate_line_counter.sv
// A result is registered when the byte that closes its group leaves the parser stage.
// One byte per cycle unless the output holds; each byte reads the store, kept ones write it.
// Results leave through an output register, so input stalls only when it is full and held.
// Reset is asynchronous and active low and clears all control state at once;
// the line store needs no clearing pass, as only entries of the open group are read.
// ----------------------------------------------------------------------------
// adjacent_duplicate_line_counter
// Counts groups of equal adjacent text records in a byte stream.
// ----------------------------------------------------------------------------
module adjacent_duplicate_line_counter #(
	parameter int MAX_LINE = adlc_pkg::MAX_LINE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [7:0] data_byte
	input  logic                             s_tlast,   // end_of_input
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [adlc_pkg::OUT_DATA_W-1:0]  m_tdata,   // [15:0] group_count, [47:16] group_start_line
	output logic                             m_tuser,   // print_it
	output logic                             m_tlast,   // final_group
	input  logic                             cfg_we,
	input  logic [adlc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [adlc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import adlc_pkg::*;

	localparam int LEN_W = $clog2(MAX_LINE + 1);
	localparam int IDX_W = $clog2(MAX_LINE);

	logic [1:0]       select_mode_q;
	logic             show_counts_q;
	logic [7:0]       skip_fields_q;
	logic [9:0]       skip_chars_q;

	logic             s1_fire;
	logic             bank_rd;
	logic             mem_we;
	logic             mem_re;
	logic [IDX_W:0]   mem_waddr;
	logic [IDX_W:0]   mem_raddr;
	logic [7:0]       mem_rdata;
	logic             valid_s1;
	item_flags_t      flags_s1;
	logic [7:0]       byte_s1;
	logic [LEN_W-1:0] cur_s1;
	logic [LEN_W-1:0] cur_new_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_mode_q <= '0;
			show_counts_q <= 1'b0;
			skip_fields_q <= '0;
			skip_chars_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SELECT_MODE: select_mode_q <= cfg_data[1:0];
				REG_SHOW_COUNTS: show_counts_q <= cfg_data[0];
				REG_SKIP_FIELDS: skip_fields_q <= cfg_data[7:0];
				REG_SKIP_CHARS:  skip_chars_q  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	adlc_parse #(
		.MAX_LINE (MAX_LINE),
		.LEN_W    (LEN_W),
		.IDX_W    (IDX_W)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.skip_fields (skip_fields_q),
		.skip_chars  (skip_chars_q),
		.s1_fire     (s1_fire),
		.bank_rd     (bank_rd),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.valid_s1    (valid_s1),
		.flags_s1    (flags_s1),
		.byte_s1     (byte_s1),
		.cur_s1      (cur_s1),
		.cur_new_s1  (cur_new_s1)
	);

	adlc_store #(
		.ADDR_W (IDX_W + 1)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (s_tdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	adlc_group #(
		.MAX_LINE (MAX_LINE),
		.LEN_W    (LEN_W)
	) u_group (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.flags_s1    (flags_s1),
		.byte_s1     (byte_s1),
		.cur_s1      (cur_s1),
		.cur_new_s1  (cur_new_s1),
		.rdata       (mem_rdata),
		.select_mode (select_mode_q),
		.show_counts (show_counts_q),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.s1_fire     (s1_fire),
		.bank_rd     (bank_rd)
	);

`ifndef SYNTHESIS
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[COUNT_W-1:0] != '0))
		else $error("result item with zero group count");

	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("result item after the final group");

	a_nothing_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && flags_s1.eoi) |=> !valid_s1)
		else $error("item entered the group stage after end of input");
`endif

endmodule
